// File: hw/rtl/unc_path_splitter_top_macros.svh
// Assertion macros shared by the path splitter RTL.
`ifndef UNC_PATH_SPLITTER_TOP_MACROS_SVH
`define UNC_PATH_SPLITTER_TOP_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define UPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define UPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ups_pkg.sv
// Types and constants for the path splitter.
package ups_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [1:0] COMP_SERVER = 2'd0;
    localparam logic [1:0] COMP_SHARE  = 2'd1;
    localparam logic [1:0] COMP_PATH   = 2'd2;

    localparam int OUTQ_DEPTH = 4;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic [1:0] component;
        logic       done_res;
        logic       status;
        logic       path_present;
    } t_result;

    // Results raised by one byte: count is 0, 1 or 2, res0 goes out first.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

// File: hw/rtl/ups_parser.sv
// Parser state and per-byte result logic.
`include "unc_path_splitter_top_macros.svh"

module ups_parser
    import ups_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_step      o_step
);

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_SERVER = 3'd1;
    localparam logic [2:0] PH_SHARE  = 3'd2;
    localparam logic [2:0] PH_PATH   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    logic [2:0] r_phase, n_phase;
    logic       r_prev, n_prev;
    logic       r_comp, n_comp;
    logic       r_held, n_held;
    logic       r_saw, n_saw;

    logic       sep;
    logic       char_now;
    logic       held_emit;
    logic [1:0] comp_code;
    logic       bad;
    logic       pp;
    t_result    chr;
    t_step      step;

    assign sep = (i_byte == CH_SLASH) || (i_byte == CH_BSLASH);

    always_comb begin
        n_phase   = r_phase;
        n_prev    = sep;
        n_comp    = r_comp;
        n_held    = r_held;
        n_saw     = r_saw;
        char_now  = 1'b0;
        held_emit = 1'b0;
        comp_code = COMP_SERVER;
        unique case (r_phase)
            PH_LEAD: begin
                n_phase = sep ? PH_SERVER : PH_ERROR;
            end
            PH_SERVER: begin
                comp_code = COMP_SERVER;
                if (sep) begin
                    if (!r_prev && r_comp) begin
                        n_phase = PH_SHARE;
                        n_comp  = 1'b0;
                    end
                end else begin
                    char_now = 1'b1;
                    n_comp   = 1'b1;
                end
            end
            PH_SHARE: begin
                comp_code = COMP_SHARE;
                if (sep) begin
                    if (!r_prev) begin
                        n_phase = PH_PATH;
                        n_saw   = 1'b1;
                        n_held  = 1'b0;
                    end
                end else begin
                    char_now = 1'b1;
                    n_comp   = 1'b1;
                end
            end
            PH_PATH: begin
                comp_code = COMP_PATH;
                if (sep) begin
                    if (!r_prev) begin
                        n_held = 1'b1;
                    end
                end else begin
                    held_emit = r_held;
                    n_held    = 1'b0;
                    char_now  = 1'b1;
                end
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase

        // status uses the state as left by this byte
        bad = !((n_phase == PH_PATH) || ((n_phase == PH_SHARE) && n_comp));
        pp  = (n_phase == PH_PATH) && n_saw;

        chr            = '0;
        chr.char_out   = i_byte;
        chr.char_valid = 1'b1;
        chr.component  = comp_code;

        step = '0;
        if (held_emit) begin
            step.count               = 2'd2;
            step.res0.char_out       = CH_SLASH;
            step.res0.char_valid     = 1'b1;
            step.res0.component      = COMP_PATH;
            step.res1                = chr;
            if (i_last) begin
                step.res1.done_res     = 1'b1;
                step.res1.status       = bad;
                step.res1.path_present = pp;
            end
        end else if (char_now) begin
            step.count = 2'd1;
            step.res0  = chr;
            if (i_last) begin
                step.res0.done_res     = 1'b1;
                step.res0.status       = bad;
                step.res0.path_present = pp;
            end
        end else if (i_last) begin
            step.count             = 2'd1;
            step.res0.done_res     = 1'b1;
            step.res0.status       = bad;
            step.res0.path_present = pp;
        end

        if (i_last) begin
            n_phase = PH_LEAD;
            n_prev  = 1'b0;
            n_comp  = 1'b0;
            n_held  = 1'b0;
            n_saw   = 1'b0;
        end
    end

    assign o_step = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_prev  <= 1'b0;
            r_comp  <= 1'b0;
            r_held  <= 1'b0;
            r_saw   <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_comp  <= n_comp;
            r_held  <= n_held;
            r_saw   <= n_saw;
        end
    end

    `UPS_ASSERT_NEXT(a_last_clears, i_take && i_last, (r_phase == PH_LEAD) && !r_held && !r_saw, "state not cleared after last byte")
    `UPS_ASSERT(a_held_in_path, !r_held || (r_phase == PH_PATH), "held separator outside path part")

endmodule

// File: hw/rtl/ups_outq.sv
// Small result queue: up to two pushes and one pop per cycle.
`include "unc_path_splitter_top_macros.svh"

module ups_outq
    import ups_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push,
    input  t_result    i_d0,
    input  t_result    i_d1,
    output logic       o_space2,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_head
);

    localparam int AW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    t_result         r_mem [OUTQ_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            pop;

    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && i_ready;
    assign o_space2 = (r_count <= CW'(OUTQ_DEPTH - 2));
    assign o_head   = r_mem[r_rd];
    assign n_count  = r_count + CW'(i_push) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_d0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(i_push);
            r_rd    <= r_rd + AW'(pop);
            r_count <= n_count;
        end
    end

    `UPS_ASSERT(a_count_bound, r_count <= CW'(OUTQ_DEPTH), "queue count beyond depth")
    `UPS_ASSERT(a_no_overflow, (i_push == 2'd0) || (n_count <= CW'(OUTQ_DEPTH)), "push into full queue")

endmodule

// File: hw/rtl/unc_path_splitter_top.sv
// Top level of the UNC path splitter.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | i_byte_in, i_is_last
//  result  | out       | o_valid / i_ready  | o_char_out, o_char_valid, o_component,
//          |           |                    | o_done_res, o_status, o_path_present
//
// One byte per cycle while o_ready is high; its results are registered into the queue and reach the result channel
// behind any results already queued. A byte raises up to two results; they go into a four-entry queue
// drained one a cycle while i_ready is high, and o_ready drops while fewer than two entries are free.
// Reset is synchronous, active low, and clears parser state and the queue.
// A stalled consumer only fills the queue; parser state moves on accepted bytes alone.
`include "unc_path_splitter_top_macros.svh"

module unc_path_splitter_top
    import ups_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte_in,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic [1:0] o_component,
    output logic       o_done_res,
    output logic       o_status,
    output logic       o_path_present
);

    logic    take;
    logic    space2;
    t_step   step;
    t_result head;

    assign o_ready = space2;
    assign take    = i_valid && space2;

    ups_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_byte_in),
        .i_last  (i_is_last),
        .o_step  (step)
    );

    ups_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (take ? step.count : 2'd0),
        .i_d0     (step.res0),
        .i_d1     (step.res1),
        .o_space2 (space2),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_head   (head)
    );

    assign o_char_out     = head.char_out;
    assign o_char_valid   = head.char_valid;
    assign o_component    = head.component;
    assign o_done_res     = head.done_res;
    assign o_status       = head.status;
    assign o_path_present = head.path_present;

    // a double result is always a flushed path separator ahead of a character
    `UPS_ASSERT(a_pair_is_sep, (step.count != 2'd2) || ((step.res0.component == COMP_PATH) && (step.res0.char_out == CH_SLASH)), "double result without held separator")
    `UPS_ASSERT(a_bad_no_path, !(o_valid && o_done_res && o_status) || !o_path_present, "invalid path flagged with path part")

endmodule
